[rtl/mmc_pkg.sv]
// Shared types, widths and constants of the magnetometer min/max calibration block.
// Used by mmc_ctrl, mmc_dp and the top level; depends on nothing else.
package mmc_pkg;

    // Sample and fixed-point format
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 8;
    localparam int OUT_BITS    = 32;
    localparam int STATUS_BITS = 8;

    // Device status value that marks a fresh sample
    localparam logic [STATUS_BITS-1:0] STATUS_READY = STATUS_BITS'(3);

    // Intermediate widths of the correction arithmetic
    localparam int N_BITS    = SAMPLE_BITS + 2;   // 2v - max - min, signed
    localparam int NMAG_BITS = SAMPLE_BITS + 1;   // |2v - max - min|
    localparam int S_BITS    = SAMPLE_BITS + 3;   // sum of three ranges, signed
    localparam int SMAG_BITS = SAMPLE_BITS + 2;
    localparam int R_BITS    = SAMPLE_BITS + 1;   // max - min, signed
    localparam int RMAG_BITS = SAMPLE_BITS;
    localparam int D_BITS    = SAMPLE_BITS + 3;   // divisor 6 * |range|
    localparam int P_BITS    = NMAG_BITS + SMAG_BITS;
    localparam int PF_BITS   = P_BITS + FRAC_BITS;

    // Divider: quotient bits retired per cycle and divider iterations per axis
    localparam int RADIX_BITS = 2;
    localparam int DIV_ITERS  = OUT_BITS / RADIX_BITS;
    localparam int CNT_BITS   = $clog2(DIV_ITERS);

    // Calibration pass-through scaling
    localparam int CAL_BITS  = SAMPLE_BITS + FRAC_BITS;
    localparam int WIDE_BITS = ((CAL_BITS > OUT_BITS) ? CAL_BITS : OUT_BITS) + 1;

    // Saturation limits
    localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [OUT_BITS-1:0]    OMAX = {1'b0, {(OUT_BITS-1){1'b1}}};
    localparam logic signed [OUT_BITS-1:0]    OMIN = {1'b1, {(OUT_BITS-1){1'b0}}};

    // Stream payload widths, padded to whole bytes
    localparam int IN_RAW_BITS   = 3 * SAMPLE_BITS;
    localparam int IN_DATA_BITS  = ((IN_RAW_BITS + 7) / 8) * 8;
    localparam int OUT_RAW_BITS  = 3 * OUT_BITS + 6 * SAMPLE_BITS;
    localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;

    // Configuration register indexes
    localparam int CFG_ADDR_BITS = 3;
    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_MODE  = 3'd0,
        CFG_MAX_X = 3'd1,
        CFG_MIN_X = 3'd2,
        CFG_MAX_Y = 3'd3,
        CFG_MIN_Y = 3'd4,
        CFG_MAX_Z = 3'd5,
        CFG_MIN_Z = 3'd6
    } t_cfg_reg;

    // Axis selector
    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } t_axis;

    // Controller to datapath commands
    typedef struct packed {
        logic  take;    // input transaction: latch sample
        logic  prep;    // form numerator, range and divisor of the axis
        logic  mul;     // product of magnitudes
        logic  chk;     // overflow check and divider start
        logic  step;    // one divider iteration
        logic  store;   // write the axis result
        logic  load;    // load the output register
        t_axis axis;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic sample_ok;
        logic cal_mode;
    } t_dp_sts;

endpackage

[rtl/mmc_ctrl.sv]
// Sequencer of the magnetometer calibration block: input and output handshakes,
// per-axis schedule and divider iteration count. Depends on mmc_pkg.
module mmc_ctrl
    import mmc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_CHK,
        ST_DIV,
        ST_STORE,
        ST_FLUSH
    } t_state;

    t_state                r_state;
    t_axis                 r_axis;
    logic [CNT_BITS-1:0]   r_cnt;
    logic                  r_out_valid;
    logic                  take;
    logic                  load;

    // Take a sample only when idle; load the result once the output register frees up
    assign o_in_ready  = (r_state == ST_IDLE);
    assign take        = i_in_valid && (r_state == ST_IDLE);
    assign load        = (r_state == ST_FLUSH) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;

    // Decode commands from state
    always_comb begin
        o_cmd       = '0;
        o_cmd.take  = take;
        o_cmd.prep  = (r_state == ST_PREP);
        o_cmd.mul   = (r_state == ST_MUL);
        o_cmd.chk   = (r_state == ST_CHK);
        o_cmd.step  = (r_state == ST_DIV);
        o_cmd.store = (r_state == ST_STORE);
        o_cmd.load  = load;
        o_cmd.axis  = r_axis;
    end

    // State, axis, iteration count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_axis      <= AXIS_X;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    r_axis <= AXIS_X;
                    if (take && i_sts.sample_ok) begin
                        r_state <= i_sts.cal_mode ? ST_FLUSH : ST_PREP;
                    end
                end
                ST_PREP: begin
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_state <= ST_CHK;
                end
                ST_CHK: begin
                    r_cnt   <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_BITS'(DIV_ITERS - 1)) begin
                        r_state <= ST_STORE;
                    end
                end
                ST_STORE: begin
                    if (r_axis == AXIS_Z) begin
                        r_state <= ST_FLUSH;
                    end else begin
                        r_axis  <= t_axis'(r_axis + 1'b1);
                        r_state <= ST_PREP;
                    end
                end
                ST_FLUSH: begin
                    if (load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Never overwrite a result that has not been taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> (!r_out_valid || i_out_ready))
        else $error("output register loaded while holding an untaken result");

    // A valid sample in normal mode starts the correction sequence
    a_start_correction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_sts.sample_ok && !i_sts.cal_mode) |=> (r_state == ST_PREP))
        else $error("correction sequence not started");

    // The divider runs the full iteration count before the result is stored
    a_div_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && r_cnt == CNT_BITS'(DIV_ITERS - 1)) |=> (r_state == ST_STORE))
        else $error("divider did not finish on its last iteration");

    // After the last axis the result goes to the output stage
    a_last_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STORE && r_axis == AXIS_Z) |=> (r_state == ST_FLUSH))
        else $error("last axis stored without moving to output");

endmodule

[rtl/mmc_dp.sv]
// Datapath of the magnetometer calibration block: configuration registers, running
// extremes, shared multiplier and radix-4 restoring divider, output register.
// Depends on mmc_pkg.
module mmc_dp
    import mmc_pkg::*;
(
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  t_dp_cmd                         i_cmd,
    output t_dp_sts                         o_sts,
    input  logic [STATUS_BITS-1:0]          i_status,
    input  logic signed [SAMPLE_BITS-1:0]   i_word_a,
    input  logic signed [SAMPLE_BITS-1:0]   i_word_b,
    input  logic signed [SAMPLE_BITS-1:0]   i_word_c,
    input  logic                            i_cfg_we,
    input  logic [CFG_ADDR_BITS-1:0]        i_cfg_addr,
    input  logic [SAMPLE_BITS-1:0]          i_cfg_wdata,
    output logic [OUT_DATA_BITS-1:0]        o_out_data
);

    // Configuration
    logic                          r_mode;
    logic signed [SAMPLE_BITS-1:0] r_cal_max [3];
    logic signed [SAMPLE_BITS-1:0] r_cal_min [3];

    // Running extremes
    logic signed [SAMPLE_BITS-1:0] r_seen_max [3];
    logic signed [SAMPLE_BITS-1:0] r_seen_min [3];

    // Sample and per-axis working registers
    logic signed [SAMPLE_BITS-1:0] r_ax [3];
    logic signed [OUT_BITS-1:0]    r_res [3];
    logic                          r_sum_neg;
    logic [SMAG_BITS-1:0]          r_sum_mag;
    logic [NMAG_BITS-1:0]          r_n_mag;
    logic [D_BITS-1:0]             r_d;
    logic                          r_neg;
    logic [P_BITS-1:0]             r_p;
    logic                          r_sat;
    logic                          r_sat_neg;
    logic [D_BITS-1:0]             r_rem;
    logic [OUT_BITS-1:0]           r_quo;
    logic [OUT_BITS-1:0]           r_pf_lo;
    logic [OUT_DATA_BITS-1:0]      r_out_data;

    // Combinational helpers
    logic signed [SAMPLE_BITS-1:0] ax_new [3];
    logic signed [S_BITS-1:0]      sum;
    logic signed [SAMPLE_BITS-1:0] sel_v;
    logic signed [SAMPLE_BITS-1:0] sel_mx;
    logic signed [SAMPLE_BITS-1:0] sel_mn;
    logic signed [N_BITS-1:0]      n_val;
    logic [N_BITS-1:0]             n_abs;
    logic signed [R_BITS-1:0]      r_val;
    logic [R_BITS-1:0]             r_abs;
    logic [D_BITS-1:0]             rmag_ext;
    logic [PF_BITS-1:0]            pf;
    logic [D_BITS:0]               trial;
    logic [D_BITS-1:0]             div_rem;
    logic [OUT_BITS-1:0]           div_quo;
    logic [OUT_BITS-1:0]           div_pf;
    logic signed [OUT_BITS-1:0]    axis_res;

    // Raw sample scaled to fixed point, saturated to the output width
    function automatic logic signed [OUT_BITS-1:0] cal_scale(
        input logic signed [SAMPLE_BITS-1:0] v
    );
        logic signed [WIDE_BITS-1:0] w;
        w = WIDE_BITS'(v) <<< FRAC_BITS;
        if (w > WIDE_BITS'(OMAX)) begin
            cal_scale = OMAX;
        end else if (w < WIDE_BITS'(OMIN)) begin
            cal_scale = OMIN;
        end else begin
            cal_scale = OUT_BITS'(w);
        end
    endfunction

    assign o_sts.sample_ok = (i_status == STATUS_READY);
    assign o_sts.cal_mode  = r_mode;
    assign o_out_data      = r_out_data;

    // Remap axes: x from the second word, y from the first, z the saturated negation
    assign ax_new[0] = i_word_b;
    assign ax_new[1] = i_word_a;
    assign ax_new[2] = (i_word_c == SMIN) ? SMAX : -i_word_c;

    // Sum of the three configured ranges
    assign sum = (S_BITS'(r_cal_max[0]) - S_BITS'(r_cal_min[0]))
               + (S_BITS'(r_cal_max[1]) - S_BITS'(r_cal_min[1]))
               + (S_BITS'(r_cal_max[2]) - S_BITS'(r_cal_min[2]));

    // Select the operands of the current axis
    always_comb begin
        unique case (i_cmd.axis)
            AXIS_X: begin
                sel_v  = r_ax[0];
                sel_mx = r_cal_max[0];
                sel_mn = r_cal_min[0];
            end
            AXIS_Y: begin
                sel_v  = r_ax[1];
                sel_mx = r_cal_max[1];
                sel_mn = r_cal_min[1];
            end
            default: begin
                sel_v  = r_ax[2];
                sel_mx = r_cal_max[2];
                sel_mn = r_cal_min[2];
            end
        endcase
    end

    // Numerator 2v - max - min, range max - min and divisor 6 * |range|
    assign n_val    = (N_BITS'(sel_v) <<< 1) - N_BITS'(sel_mx) - N_BITS'(sel_mn);
    assign n_abs    = n_val[N_BITS-1] ? N_BITS'(-n_val) : N_BITS'(n_val);
    assign r_val    = R_BITS'(sel_mx) - R_BITS'(sel_mn);
    assign r_abs    = r_val[R_BITS-1] ? R_BITS'(-r_val) : R_BITS'(r_val);
    assign rmag_ext = D_BITS'(r_abs[RMAG_BITS-1:0]);

    // Scaled product feeding the divider
    assign pf = {r_p, {FRAC_BITS{1'b0}}};

    // Two restoring divide steps per cycle
    always_comb begin
        div_rem = r_rem;
        div_quo = r_quo;
        div_pf  = r_pf_lo;
        trial   = '0;
        for (int k = 0; k < RADIX_BITS; k++) begin
            trial  = {div_rem, div_pf[OUT_BITS-1]};
            div_pf = div_pf << 1;
            if (trial >= {1'b0, r_d}) begin
                div_rem = D_BITS'(trial - {1'b0, r_d});
                div_quo = {div_quo[OUT_BITS-2:0], 1'b1};
            end else begin
                div_rem = D_BITS'(trial);
                div_quo = {div_quo[OUT_BITS-2:0], 1'b0};
            end
        end
    end

    // Signed and saturated axis result
    always_comb begin
        if (r_sat) begin
            axis_res = r_sat_neg ? OMIN : OMAX;
        end else if (r_neg) begin
            axis_res = -$signed(r_quo);
        end else begin
            axis_res = $signed(r_quo);
        end
    end

    // Configuration registers and running extremes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_cal_max[k]  <= SMAX;
                r_cal_min[k]  <= SMIN;
                r_seen_max[k] <= SMIN;
                r_seen_min[k] <= SMAX;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_MODE:  r_mode       <= i_cfg_wdata[0];
                    CFG_MAX_X: r_cal_max[0] <= $signed(i_cfg_wdata);
                    CFG_MIN_X: r_cal_min[0] <= $signed(i_cfg_wdata);
                    CFG_MAX_Y: r_cal_max[1] <= $signed(i_cfg_wdata);
                    CFG_MIN_Y: r_cal_min[1] <= $signed(i_cfg_wdata);
                    CFG_MAX_Z: r_cal_max[2] <= $signed(i_cfg_wdata);
                    CFG_MIN_Z: r_cal_min[2] <= $signed(i_cfg_wdata);
                    default: ;
                endcase
            end
            // Widen the extremes with each valid sample in calibration mode
            if (i_cmd.take && o_sts.sample_ok && r_mode) begin
                for (int k = 0; k < 3; k++) begin
                    if (ax_new[k] > r_seen_max[k]) begin
                        r_seen_max[k] <= ax_new[k];
                    end
                    if (ax_new[k] < r_seen_min[k]) begin
                        r_seen_min[k] <= ax_new[k];
                    end
                end
            end
        end
    end

    // Working registers of the correction sequence
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            for (int k = 0; k < 3; k++) begin
                r_ax[k]  <= ax_new[k];
                r_res[k] <= cal_scale(ax_new[k]);
            end
            r_sum_neg <= sum[S_BITS-1];
            r_sum_mag <= SMAG_BITS'(sum[S_BITS-1] ? -sum : sum);
        end
        if (i_cmd.prep) begin
            r_n_mag <= n_abs[NMAG_BITS-1:0];
            r_d     <= (rmag_ext << 2) + (rmag_ext << 1);
            r_neg   <= n_val[N_BITS-1] ^ r_val[R_BITS-1] ^ r_sum_neg;
        end
        if (i_cmd.mul) begin
            r_p <= P_BITS'(r_n_mag) * P_BITS'(r_sum_mag);
        end
        // Quotient would reach the sign bit: saturate; a zero range lands here as well
        if (i_cmd.chk) begin
            r_sat     <= (pf >> (OUT_BITS - 1)) >= PF_BITS'(r_d);
            r_sat_neg <= r_neg && (r_p != '0);
            r_rem     <= D_BITS'(pf >> OUT_BITS);
            r_pf_lo   <= OUT_BITS'(pf);
            r_quo     <= '0;
        end
        if (i_cmd.step) begin
            r_rem   <= div_rem;
            r_quo   <= div_quo;
            r_pf_lo <= div_pf;
        end
        if (i_cmd.store) begin
            unique case (i_cmd.axis)
                AXIS_X:  r_res[0] <= axis_res;
                AXIS_Y:  r_res[1] <= axis_res;
                default: r_res[2] <= axis_res;
            endcase
        end
        if (i_cmd.load) begin
            r_out_data <= OUT_DATA_BITS'({r_seen_min[2], r_seen_max[2],
                                          r_seen_min[1], r_seen_max[1],
                                          r_seen_min[0], r_seen_max[0],
                                          r_res[2], r_res[1], r_res[0]});
        end
    end

endmodule

[rtl/magnetometer_minmax_calibration.sv]
// Top level of the magnetometer min/max (hard and soft iron) calibration block.
// Joins mmc_ctrl and mmc_dp; depends on mmc_pkg.
//
// Each input transaction carries one sample; it is used only when the status in tuser
// equals 3, otherwise it is dropped with no result. The block takes one sample at a time
// and holds tready low while it works. In calibration mode the sample skips the correction
// and its result goes to the output register. In normal mode the three axes go in turn:
// they share one 18 x 17 bit multiplier and one restoring divider
// that retires two quotient bits a cycle over a 32 bit quotient. The finished
// result waits in the output register, so a new sample can be taken while it is unread.
module magnetometer_minmax_calibration
    import mmc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Sample stream
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    input  logic [IN_DATA_BITS-1:0]  i_s_axis_tdata,  // raw_word_a, raw_word_b, raw_word_c
    input  logic [STATUS_BITS-1:0]   i_s_axis_tuser,  // status_byte
    // Result stream
    output logic                     o_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    // x_out, y_out, z_out, peak_x, trough_x, peak_y, trough_y, peak_z, trough_z
    output logic [OUT_DATA_BITS-1:0] o_m_axis_tdata,
    // Configuration writes
    input  logic                     i_cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  logic [SAMPLE_BITS-1:0]   i_cfg_wdata
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    mmc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    mmc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_status    (i_s_axis_tuser),
        .i_word_a    ($signed(i_s_axis_tdata[SAMPLE_BITS-1:0])),
        .i_word_b    ($signed(i_s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS])),
        .i_word_c    ($signed(i_s_axis_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS])),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_data  (o_m_axis_tdata)
    );

endmodule

[dv/tb_magnetometer_minmax_calibration.sv]
// Self-checking testbench for the magnetometer min/max calibration block.
// Drives samples and register writes, predicts every reading in SystemVerilog and
// compares it field by field; depends on mmc_pkg and magnetometer_minmax_calibration.
`timescale 1ns / 100ps

module tb_magnetometer_minmax_calibration;
    import mmc_pkg::*;

    localparam int CYCLE_LIMIT     = 1000000;
    localparam int SETTLE_CYCLES   = 100;
    localparam int ITEMS_PER_BLOCK = 170;
    localparam int RANDOM_BLOCKS   = 10;
    localparam int REPORT_LIMIT    = 10;

    // Index past the end of the register list; writes to it must be ignored
    localparam logic [CFG_ADDR_BITS-1:0] CFG_UNUSED = 3'd7;

    // Kinds of calibration setting used by the random blocks
    typedef enum int {
        SET_CAL,
        SET_WIDE,
        SET_NARROW,
        SET_REVERSED,
        SET_FULL,
        SET_FLAT
    } t_cal_setting;

    // One reading, laid out as it travels in the result tdata (last field lowest)
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] trough_z;
        logic signed [SAMPLE_BITS-1:0] peak_z;
        logic signed [SAMPLE_BITS-1:0] trough_y;
        logic signed [SAMPLE_BITS-1:0] peak_y;
        logic signed [SAMPLE_BITS-1:0] trough_x;
        logic signed [SAMPLE_BITS-1:0] peak_x;
        logic signed [OUT_BITS-1:0]    z_out;
        logic signed [OUT_BITS-1:0]    y_out;
        logic signed [OUT_BITS-1:0]    x_out;
    } t_mag_reading;

    typedef logic signed [OUT_BITS-1:0] t_field_set [9];

    // A sample as offered, with a hand-written reading where one is known
    typedef struct {
        bit           is_fixed;
        t_mag_reading reading;
    } t_offered;

    // Row of the directed table: a register write or a sample
    typedef struct {
        bit                       is_write;
        logic [CFG_ADDR_BITS-1:0] addr;
        logic [SAMPLE_BITS-1:0]   wdata;
        logic [STATUS_BITS-1:0]   status;
        logic [SAMPLE_BITS-1:0]   word_a;
        logic [SAMPLE_BITS-1:0]   word_b;
        logic [SAMPLE_BITS-1:0]   word_c;
        bit                       is_fixed;
        t_mag_reading             reading;
    } t_plan_row;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_s_axis_tvalid;
    logic                     o_s_axis_tready;
    logic [IN_DATA_BITS-1:0]  i_s_axis_tdata;   // raw_word_a, raw_word_b, raw_word_c
    logic [STATUS_BITS-1:0]   i_s_axis_tuser;   // status_byte
    logic                     o_m_axis_tvalid;
    logic                     i_m_axis_tready;
    // x_out, y_out, z_out, peak_x, trough_x, peak_y, trough_y, peak_z, trough_z
    logic [OUT_DATA_BITS-1:0] o_m_axis_tdata;
    logic                     i_cfg_we;
    logic [CFG_ADDR_BITS-1:0] i_cfg_addr;
    logic [SAMPLE_BITS-1:0]   i_cfg_wdata;

    // Predictor copy of registers and running extremes
    logic                          cal_mode_m;
    logic signed [SAMPLE_BITS-1:0] cal_hi [3];
    logic signed [SAMPLE_BITS-1:0] cal_lo [3];
    logic signed [SAMPLE_BITS-1:0] seen_hi [3];
    logic signed [SAMPLE_BITS-1:0] seen_lo [3];

    t_mag_reading expected_readings [$];
    t_offered     offered_samples [$];
    t_plan_row    plan [$];

    int unsigned  mismatch_count;
    int unsigned  reading_index;
    int unsigned  cycle_count;
    int           send_idle_pct;
    int           recv_stall_pct;

    string field_names [9] = '{"x_out", "y_out", "z_out", "peak_x", "trough_x",
                               "peak_y", "trough_y", "peak_z", "trough_z"};

    magnetometer_minmax_calibration dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    // Clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Result side back-pressure
    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Abort a run that hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Exact corrected value of one axis: trunc((2v-max-min)*S*2^F / (6R)), saturated
    function automatic logic signed [OUT_BITS-1:0] corrected_axis(
        input longint v, input longint mx, input longint mn, input longint s);
        longint            n;
        longint            r;
        bit                neg;
        longint unsigned   p;
        longint unsigned   d;
        longint unsigned   q;
        longint unsigned   rem;
        longint unsigned   m;
        n   = 2 * v - mx - mn;
        r   = mx - mn;
        neg = ((n < 0) != (s < 0));
        // Zero range: saturate by the sign of the numerator
        if (r == 0)
            return (neg && n != 0 && s != 0) ? OMIN : OMAX;
        if (r < 0)
            neg = !neg;
        p   = longint'((n < 0) ? -n : n) * longint'((s < 0) ? -s : s);
        d   = 6 * longint'((r < 0) ? -r : r);
        q   = p / d;
        rem = p % d;
        if ((q >> (OUT_BITS - 1 - FRAC_BITS)) != 0)
            return neg ? OMIN : OMAX;
        m = (q << FRAC_BITS) + ((rem << FRAC_BITS) / d);
        if (neg)
            return (m >= 64'd2147483648) ? OMIN : OUT_BITS'(-longint'(m));
        return (m > 64'd2147483647) ? OMAX : OUT_BITS'(m);
    endfunction

    // Work out the reading caused by one sample and advance the running extremes
    task automatic predict_reading(input logic [STATUS_BITS-1:0] status,
                                   input logic [SAMPLE_BITS-1:0] word_a,
                                   input logic [SAMPLE_BITS-1:0] word_b,
                                   input logic [SAMPLE_BITS-1:0] word_c,
                                   output bit produced, output t_mag_reading r);
        logic signed [SAMPLE_BITS-1:0] ax [3];
        logic signed [OUT_BITS-1:0]    res [3];
        longint                        span;
        int                            i;
        produced = (status == STATUS_READY);
        r        = '0;
        if (!produced)
            return;
        // Remap axes; z is the negated third word, saturated
        ax[0] = word_b;
        ax[1] = word_a;
        ax[2] = ($signed(word_c) == SMIN) ? SMAX : -$signed(word_c);
        if (cal_mode_m) begin
            for (i = 0; i < 3; i++) begin
                if (ax[i] > seen_hi[i]) seen_hi[i] = ax[i];
                if (ax[i] < seen_lo[i]) seen_lo[i] = ax[i];
                res[i] = OUT_BITS'(longint'(ax[i]) * (longint'(1) << FRAC_BITS));
            end
        end else begin
            span = 0;
            for (i = 0; i < 3; i++)
                span += longint'(cal_hi[i]) - longint'(cal_lo[i]);
            for (i = 0; i < 3; i++)
                res[i] = corrected_axis(ax[i], cal_hi[i], cal_lo[i], span);
        end
        r.x_out    = res[0];
        r.y_out    = res[1];
        r.z_out    = res[2];
        r.peak_x   = seen_hi[0];
        r.trough_x = seen_lo[0];
        r.peak_y   = seen_hi[1];
        r.trough_y = seen_lo[1];
        r.peak_z   = seen_hi[2];
        r.trough_z = seen_lo[2];
    endtask

    function automatic t_field_set split_reading(input t_mag_reading r);
        t_field_set f;
        f = '{r.x_out, r.y_out, r.z_out, r.peak_x, r.trough_x,
              r.peak_y, r.trough_y, r.peak_z, r.trough_z};
        return f;
    endfunction

    // Track register writes, predict at input transactions, check output transactions
    always @(posedge i_clk) begin : monitor
        t_mag_reading predicted;
        t_mag_reading want;
        t_mag_reading got;
        t_offered     note;
        bit           produced;
        t_field_set   wf;
        t_field_set   gf;
        int           i;
        if (!i_rst_n) begin
            cal_mode_m = 1'b0;
            for (i = 0; i < 3; i++) begin
                cal_hi[i]  = SMAX;
                cal_lo[i]  = SMIN;
                seen_hi[i] = SMIN;
                seen_lo[i] = SMAX;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_MODE:  cal_mode_m = i_cfg_wdata[0];
                    CFG_MAX_X: cal_hi[0]  = i_cfg_wdata;
                    CFG_MIN_X: cal_lo[0]  = i_cfg_wdata;
                    CFG_MAX_Y: cal_hi[1]  = i_cfg_wdata;
                    CFG_MIN_Y: cal_lo[1]  = i_cfg_wdata;
                    CFG_MAX_Z: cal_hi[2]  = i_cfg_wdata;
                    CFG_MIN_Z: cal_lo[2]  = i_cfg_wdata;
                    default: ;  // beyond the register list: ignored
                endcase
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                note = '{is_fixed: 1'b0, reading: '0};
                if (offered_samples.size() != 0)
                    note = offered_samples.pop_front();
                predict_reading(i_s_axis_tuser, i_s_axis_tdata[15:0],
                                i_s_axis_tdata[31:16], i_s_axis_tdata[47:32],
                                produced, predicted);
                if (produced)
                    expected_readings.push_back(note.is_fixed ? note.reading : predicted);
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = t_mag_reading'(o_m_axis_tdata);
                if (expected_readings.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("reading %0d arrived with none expected: %h",
                                 reading_index, o_m_axis_tdata);
                end else begin
                    want = expected_readings.pop_front();
                    wf   = split_reading(want);
                    gf   = split_reading(got);
                    for (i = 0; i < 9; i++) begin
                        if (wf[i] !== gf[i]) begin
                            mismatch_count++;
                            if (mismatch_count <= REPORT_LIMIT)
                                $display("reading %0d %s: expected %0d, got %0d",
                                         reading_index, field_names[i], wf[i], gf[i]);
                        end
                    end
                end
                reading_index++;
            end
        end
    end

    // Directed table builders
    function automatic void add_write(input logic [CFG_ADDR_BITS-1:0] addr,
                                      input logic [SAMPLE_BITS-1:0] wdata);
        t_plan_row row;
        row          = '{default: '0};
        row.is_write = 1'b1;
        row.addr     = addr;
        row.wdata    = wdata;
        plan.push_back(row);
    endfunction

    function automatic void add_sample(input logic [STATUS_BITS-1:0] status,
                                       input logic [SAMPLE_BITS-1:0] a,
                                       input logic [SAMPLE_BITS-1:0] b,
                                       input logic [SAMPLE_BITS-1:0] c,
                                       input bit is_fixed, input t_mag_reading reading);
        t_plan_row row;
        row          = '{default: '0};
        row.status   = status;
        row.word_a   = a;
        row.word_b   = b;
        row.word_c   = c;
        row.is_fixed = is_fixed;
        row.reading  = reading;
        plan.push_back(row);
    endfunction

    function automatic t_mag_reading make_reading(input int x, input int y, input int z,
                                                  input int px, input int tx,
                                                  input int py, input int ty,
                                                  input int pz, input int tz);
        t_mag_reading r;
        r.x_out    = x;
        r.y_out    = y;
        r.z_out    = z;
        r.peak_x   = SAMPLE_BITS'(px);
        r.trough_x = SAMPLE_BITS'(tx);
        r.peak_y   = SAMPLE_BITS'(py);
        r.trough_y = SAMPLE_BITS'(ty);
        r.peak_z   = SAMPLE_BITS'(pz);
        r.trough_z = SAMPLE_BITS'(tz);
        return r;
    endfunction

    // Offer one sample and hold it until the input transaction completes
    task automatic offer_sample(input logic [STATUS_BITS-1:0] status,
                                input logic [SAMPLE_BITS-1:0] a,
                                input logic [SAMPLE_BITS-1:0] b,
                                input logic [SAMPLE_BITS-1:0] c,
                                input bit is_fixed, input t_mag_reading reading);
        offered_samples.push_back('{is_fixed: is_fixed, reading: reading});
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= status;
        i_s_axis_tdata  <= {c, b, a};
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    // Hold the sender until every reading is in, then let a dropped sample finish
    task automatic drain_readings();
        i_s_axis_tvalid <= 1'b0;
        while (expected_readings.size() != 0 || offered_samples.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_ADDR_BITS-1:0] addr,
                                  input logic [SAMPLE_BITS-1:0] wdata);
        drain_readings();
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= wdata;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Mostly random words, with the extremes and a band around zero weighted up
    function automatic logic [SAMPLE_BITS-1:0] rand_word();
        logic [SAMPLE_BITS-1:0] corner [6];
        corner = '{16'h8000, 16'h8001, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF};
        case ($urandom_range(0, 9))
            0, 1:       return corner[$urandom_range(0, 5)];
            2, 3, 4, 5: return SAMPLE_BITS'($urandom);
            default:    return SAMPLE_BITS'($urandom_range(0, 2000) - 1000);
        endcase
    endfunction

    // Choose and write a full calibration setting for one random block
    task automatic configure_block(input t_cal_setting kind);
        int hi [3];
        int lo [3];
        int p;
        int q;
        int centre;
        int half;
        int i;
        bit mode;
        mode = (kind == SET_CAL);
        for (i = 0; i < 3; i++) begin
            p = int'($urandom_range(0, 65535)) - 32768;
            q = int'($urandom_range(0, 65535)) - 32768;
            case (kind)
                SET_NARROW: begin
                    centre = int'($urandom_range(0, 2000)) - 1000;
                    half   = $urandom_range(0, 40);
                    hi[i]  = centre + half;
                    lo[i]  = centre - half;
                end
                SET_REVERSED: begin
                    hi[i] = (p < q) ? p : q;
                    lo[i] = (p < q) ? q : p;
                end
                SET_FULL: begin
                    hi[i] = (i == 2) ? -32768 : 32767;
                    lo[i] = (i == 2) ? 32767 : -32768;
                end
                default: begin
                    hi[i] = (p > q) ? p : q;
                    lo[i] = (p > q) ? q : p;
                end
            endcase
        end
        // Flat x axis: zero range
        if (kind == SET_FLAT)
            lo[0] = hi[0];
        write_register(CFG_MODE, SAMPLE_BITS'(mode));
        write_register(CFG_MAX_X, SAMPLE_BITS'(hi[0]));
        write_register(CFG_MIN_X, SAMPLE_BITS'(lo[0]));
        write_register(CFG_MAX_Y, SAMPLE_BITS'(hi[1]));
        write_register(CFG_MIN_Y, SAMPLE_BITS'(lo[1]));
        write_register(CFG_MAX_Z, SAMPLE_BITS'(hi[2]));
        write_register(CFG_MIN_Z, SAMPLE_BITS'(lo[2]));
    endtask

    // Stimulus
    initial begin
        t_cal_setting block_kind [RANDOM_BLOCKS];
        int           block;
        logic [STATUS_BITS-1:0] status;

        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= '0;
        i_cfg_we        <= 1'b0;
        i_cfg_addr      <= CFG_MODE;
        i_cfg_wdata     <= '0;
        send_idle_pct   = 0;
        recv_stall_pct  <= 0;

        block_kind = '{SET_CAL, SET_WIDE, SET_NARROW, SET_CAL, SET_REVERSED,
                       SET_FULL, SET_NARROW, SET_FLAT, SET_CAL, SET_WIDE};

        // Correction with the reset calibration limits gives 256 * v + 128
        add_sample(STATUS_READY, 16'h0000, 16'h0000, 16'h0000, 1'b1,
                   make_reading(128, 128, 128, -32768, 32767, -32768, 32767, -32768, 32767));
        add_sample(STATUS_READY, 16'h7FFF, 16'h8000, 16'h8000, 1'b1,
                   make_reading(-8388480, 8388480, 8388480,
                                -32768, 32767, -32768, 32767, -32768, 32767));
        add_sample(STATUS_READY, 16'h8000, 16'h7FFF, 16'h7FFF, 1'b1,
                   make_reading(8388480, -8388480, -8388224,
                                -32768, 32767, -32768, 32767, -32768, 32767));
        // Status other than ready: dropped
        add_sample(8'h00, 16'h1234, 16'h5678, 16'h9ABC, 1'b0, '0);
        add_sample(8'hFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, '0);
        add_sample(8'h02, 16'h8000, 16'h8000, 16'h8000, 1'b0, '0);
        // Calibration: raw values pass through and the extremes widen
        add_write(CFG_MODE, 16'h0001);
        add_sample(STATUS_READY, 16'h0000, 16'h0000, 16'h0000, 1'b1,
                   make_reading(0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_sample(STATUS_READY, 16'h7FFF, 16'h8000, 16'h8000, 1'b1,
                   make_reading(-8388608, 8388352, 8388352, 0, -32768, 32767, 0, 32767, 0));
        add_sample(8'h83, 16'h8000, 16'h7FFF, 16'h7FFF, 1'b0, '0);
        add_sample(STATUS_READY, 16'h8000, 16'h7FFF, 16'h7FFF, 1'b1,
                   make_reading(8388352, -8388608, -8388352,
                                32767, -32768, 32767, -32768, 32767, -32767));
        // Flat x, reversed y, narrow z; then a write past the register list
        add_write(CFG_MODE, 16'h0000);
        add_write(CFG_MAX_X, 16'd100);
        add_write(CFG_MIN_X, 16'd100);
        add_write(CFG_MAX_Y, -16'sd1000);
        add_write(CFG_MIN_Y, 16'd1000);
        add_write(CFG_MAX_Z, 16'd10);
        add_write(CFG_MIN_Z, -16'sd10);
        add_write(CFG_UNUSED, 16'hFFFF);
        add_sample(STATUS_READY, 16'h0000, 16'd100, 16'h0000, 1'b0, '0);
        add_sample(STATUS_READY, 16'd5, -16'sd5, -16'sd20, 1'b0, '0);
        add_sample(STATUS_READY, 16'h8000, 16'h7FFF, 16'h8000, 1'b0, '0);
        add_sample(STATUS_READY, 16'd1000, 16'hFFFF, 16'h0001, 1'b0, '0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        foreach (plan[i]) begin
            if (plan[i].is_write)
                write_register(plan[i].addr, plan[i].wdata);
            else
                offer_sample(plan[i].status, plan[i].word_a, plan[i].word_b,
                             plan[i].word_c, plan[i].is_fixed, plan[i].reading);
        end

        // Random blocks, each with its own setting and idling phase
        for (block = 0; block < RANDOM_BLOCKS; block++) begin
            configure_block(block_kind[block]);
            case (block % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct <= 86; end
                default: begin send_idle_pct = 33; recv_stall_pct <= 33; end
            endcase
            repeat (ITEMS_PER_BLOCK) begin
                status = ($urandom_range(0, 3) != 0) ? STATUS_READY : STATUS_BITS'($urandom);
                offer_sample(status, rand_word(), rand_word(), rand_word(), 1'b0, '0);
            end
        end

        drain_readings();
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
